FILE: rtl/core/sfrd_pkg.sv
// Shared constants, types and field table for the status frame receiver and decoder.
package sfrd_pkg;

    localparam int FRAME_BYTES = 128;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int BYTE_W      = 8;
    localparam int VAL_W       = 10;
    localparam int FID_W       = 5;
    localparam int NUM_FIELDS  = 28;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 4;

    localparam int FIRST_FIELD_POS = 4;
    localparam int LAST_FIELD_POS  = 75;

    localparam logic [BYTE_W-1:0] CH_START  = 8'h25;  // '%'
    localparam logic [BYTE_W-1:0] CH_TERM   = 8'h5E;  // '^'
    localparam logic [BYTE_W-1:0] CH_REINIT = 8'h52;  // 'R'
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;  // '9'

    localparam logic [VAL_W-1:0]  EXT_CAP_RST   = 10'd320;
    localparam logic [VAL_W-1:0]  BED_CAP_RST   = 10'd150;
    localparam logic [VAL_W-1:0]  PCT_CAP_RST   = 10'd100;
    localparam logic [BYTE_W-1:0] ADDR_CHAR_RST = 8'h49;  // 'I'

    typedef enum logic [1:0] {
        REG_EXT_CAP,
        REG_BED_CAP,
        REG_PCT_CAP,
        REG_ADDR_CHAR
    } cfg_reg_t;

    // field indexes that take part in clamping
    localparam logic [FID_W-1:0] FLD_X_POS   = 5'd15;
    localparam logic [FID_W-1:0] FLD_Y_POS   = 5'd16;
    localparam logic [FID_W-1:0] FLD_Z_POS   = 5'd17;
    localparam logic [FID_W-1:0] FLD_X_MAX   = 5'd18;
    localparam logic [FID_W-1:0] FLD_Y_MAX   = 5'd19;
    localparam logic [FID_W-1:0] FLD_Z_MAX   = 5'd20;
    localparam logic [FID_W-1:0] FLD_L1_USED = 5'd21;
    localparam logic [FID_W-1:0] FLD_L2_USED = 5'd22;
    localparam logic [FID_W-1:0] FLD_L1_MAX  = 5'd23;
    localparam logic [FID_W-1:0] FLD_L2_MAX  = 5'd24;

    localparam int NUM_CLAMP = 5;
    localparam int CL_W      = $clog2(NUM_CLAMP);
    localparam logic [CL_W-1:0] CL_X  = 3'd0;
    localparam logic [CL_W-1:0] CL_Y  = 3'd1;
    localparam logic [CL_W-1:0] CL_Z  = 3'd2;
    localparam logic [CL_W-1:0] CL_L1 = 3'd3;
    localparam logic [CL_W-1:0] CL_L2 = 3'd4;

    typedef enum logic [2:0] {
        KIND_EXT,
        KIND_BED,
        KIND_PCT,
        KIND_NUM,
        KIND_RAW,
        KIND_RST
    } field_kind_t;

    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_SCAN,
        DEC_DRAIN
    } dec_state_t;

    typedef enum logic [1:0] {
        EMT_IDLE,
        EMT_READ,
        EMT_SHOW
    } emt_state_t;

    typedef struct packed {
        logic              en;
        logic [FID_W-1:0]  addr;
        logic              bad;
        logic [VAL_W-1:0]  val;
    } res_wr_t;

    typedef struct packed {
        logic [NUM_CLAMP-1:0]            bad;
        logic [NUM_CLAMP-1:0][VAL_W-1:0] val;
    } clamp_info_t;

    typedef struct packed {
        logic             start;
        logic [FID_W-1:0] count;
    } emit_req_t;

    function automatic field_kind_t field_kind(input logic [FID_W-1:0] idx);
        field_kind_t k;
        priority if (idx <= 5'd1)  k = KIND_EXT;
        else if (idx == 5'd2)      k = KIND_BED;
        else if (idx <= 5'd4)      k = KIND_EXT;
        else if (idx == 5'd5)      k = KIND_BED;
        else if (idx <= 5'd11)     k = KIND_PCT;
        else if (idx <= 5'd14)     k = KIND_RAW;
        else if (idx <= 5'd24)     k = KIND_NUM;
        else if (idx <= 5'd26)     k = KIND_RAW;
        else                       k = KIND_RST;
        return k;
    endfunction

    // one past the field's last byte
    function automatic logic [POS_W-1:0] field_end(input logic [FID_W-1:0] idx);
        int e;
        priority if (idx < 5'd12) e = 7 + 3 * int'(idx);
        else if (idx < 5'd15)     e = 29 + int'(idx);
        else if (idx < 5'd25)     e = 1 + 3 * int'(idx);
        else                      e = 49 + int'(idx);
        return POS_W'(e);
    endfunction

endpackage

FILE: rtl/core/sfrd_frame_mem.sv
// Frame byte store: one write port, one registered read port.
module sfrd_frame_mem (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [sfrd_pkg::ADDR_W-1:0]         wr_addr,
    input  logic [sfrd_pkg::BYTE_W-1:0]         wr_data,
    input  logic                                rd_en,
    input  logic [sfrd_pkg::ADDR_W-1:0]         rd_addr,
    output logic [sfrd_pkg::BYTE_W-1:0]         rd_data
);
    import sfrd_pkg::*;

    logic [BYTE_W-1:0] mem [FRAME_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/sfrd_decoder.sv
// Frame scanner: address test and per-field decode, streaming the frame store.
module sfrd_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sfrd_pkg::POS_W-1:0]    count,
    input  logic [sfrd_pkg::VAL_W-1:0]    ext_cap,
    input  logic [sfrd_pkg::VAL_W-1:0]    bed_cap,
    input  logic [sfrd_pkg::VAL_W-1:0]    pct_cap,
    input  logic [sfrd_pkg::BYTE_W-1:0]   addr_char,
    output logic                          rd_en,
    output logic [sfrd_pkg::ADDR_W-1:0]   rd_addr,
    input  logic [sfrd_pkg::BYTE_W-1:0]   rd_data,
    output sfrd_pkg::res_wr_t             res_wr,
    output sfrd_pkg::clamp_info_t         clamp_info,
    output sfrd_pkg::emit_req_t           emit_req,
    output logic                          busy
);
    import sfrd_pkg::*;

    localparam int SUM_W = VAL_W + 4;

    dec_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]  rd_pos_reg, rd_pos_next;
    logic               proc_valid_reg, proc_valid_next;
    logic [ADDR_W-1:0]  proc_pos_reg, proc_pos_next;
    logic [POS_W-1:0]   count_reg, count_next;
    logic [1:0]         match_reg, match_next;
    logic [FID_W-1:0]   fld_reg, fld_next;
    logic [1:0]         dig_reg, dig_next;
    logic [VAL_W-1:0]   acc_reg, acc_next;
    logic               bad_reg, bad_next;
    logic [FID_W-1:0]   n_reg, n_next;
    clamp_info_t        clamp_reg, clamp_next;

    field_kind_t        kind;
    logic               is_digit;
    logic [BYTE_W-1:0]  digit_byte;
    logic [SUM_W-1:0]   acc_sum;
    logic               bad_now;
    logic               done;
    logic               fbad;
    logic [VAL_W-1:0]   fval;
    logic [VAL_W-1:0]   raw_val;
    logic [VAL_W-1:0]   cap_val;
    logic               has_cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= DEC_IDLE;
            proc_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            proc_valid_reg <= proc_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg   <= rd_pos_next;
        proc_pos_reg <= proc_pos_next;
        count_reg    <= count_next;
        match_reg    <= match_next;
        fld_reg      <= fld_next;
        dig_reg      <= dig_next;
        acc_reg      <= acc_next;
        bad_reg      <= bad_next;
        n_reg        <= n_next;
        clamp_reg    <= clamp_next;
    end

    assign kind       = field_kind(fld_reg);
    assign is_digit   = (rd_data >= CH_ZERO) && (rd_data <= CH_NINE);
    assign digit_byte = rd_data - CH_ZERO;
    assign acc_sum    = SUM_W'(acc_reg) * SUM_W'(10) + SUM_W'(digit_byte[3:0]);
    assign bad_now    = bad_reg | ~is_digit;

    always_comb
    begin
        has_cap = 1'b1;
        cap_val = ext_cap;
        unique case (kind)
            KIND_EXT: cap_val = ext_cap;
            KIND_BED: cap_val = bed_cap;
            KIND_PCT: cap_val = pct_cap;
            default:  has_cap = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_pos_next     = rd_pos_reg;
        proc_valid_next = proc_valid_reg;
        proc_pos_next   = proc_pos_reg;
        count_next      = count_reg;
        match_next      = match_reg;
        fld_next        = fld_reg;
        dig_next        = dig_reg;
        acc_next        = acc_reg;
        bad_next        = bad_reg;
        n_next          = n_reg;
        clamp_next      = clamp_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_pos_reg;
        res_wr          = '0;
        emit_req        = '0;
        done            = 1'b0;
        fbad            = 1'b0;
        fval            = '0;
        raw_val         = '0;

        // byte read in the previous cycle
        if (proc_valid_reg)
        begin
            if (proc_pos_reg < ADDR_W'(FIRST_FIELD_POS))
            begin
                if (rd_data == addr_char)
                begin
                    match_next = match_reg + 2'd1;
                end
            end
            else if (kind == KIND_RAW || kind == KIND_RST)
            begin
                done = 1'b1;
                fval = (kind == KIND_RST) ? VAL_W'(rd_data == CH_REINIT) : VAL_W'(rd_data);
            end
            else
            begin
                acc_next = acc_sum[VAL_W-1:0];
                bad_next = bad_now;
                dig_next = dig_reg + 2'd1;
                if (dig_reg == 2'd2)
                begin
                    done    = 1'b1;
                    fbad    = bad_now;
                    raw_val = bad_now ? '0 : acc_sum[VAL_W-1:0];
                    fval    = (has_cap && raw_val > cap_val) ? cap_val : raw_val;
                end
            end

            if (done)
            begin
                dig_next = '0;
                acc_next = '0;
                bad_next = 1'b0;
                fld_next = fld_reg + 5'd1;
                // present only when wholly before the terminator
                if (field_end(fld_reg) < count_reg)
                begin
                    res_wr.en   = 1'b1;
                    res_wr.addr = fld_reg;
                    res_wr.bad  = fbad;
                    res_wr.val  = fval;
                    n_next      = fld_reg + 5'd1;
                    if (fld_reg == FLD_X_MAX)
                    begin
                        clamp_next.val[CL_X] = fval;
                        clamp_next.bad[CL_X] = fbad;
                    end
                    if (fld_reg == FLD_Y_MAX)
                    begin
                        clamp_next.val[CL_Y] = fval;
                        clamp_next.bad[CL_Y] = fbad;
                    end
                    if (fld_reg == FLD_Z_MAX)
                    begin
                        clamp_next.val[CL_Z] = fval;
                        clamp_next.bad[CL_Z] = fbad;
                    end
                    if (fld_reg == FLD_L1_MAX)
                    begin
                        clamp_next.val[CL_L1] = fval;
                        clamp_next.bad[CL_L1] = fbad;
                    end
                    if (fld_reg == FLD_L2_MAX)
                    begin
                        clamp_next.val[CL_L2] = fval;
                        clamp_next.bad[CL_L2] = fbad;
                    end
                end
            end
        end

        unique case (state_reg)
            DEC_IDLE:
            begin
                if (start)
                begin
                    count_next      = count;
                    rd_pos_next     = ADDR_W'(1);
                    proc_valid_next = 1'b0;
                    match_next      = '0;
                    fld_next        = '0;
                    dig_next        = '0;
                    acc_next        = '0;
                    bad_next        = 1'b0;
                    n_next          = '0;
                    state_next      = DEC_SCAN;
                end
            end
            DEC_SCAN:
            begin
                rd_en           = 1'b1;
                proc_valid_next = 1'b1;
                proc_pos_next   = rd_pos_reg;
                rd_pos_next     = rd_pos_reg + ADDR_W'(1);
                if (rd_pos_reg == ADDR_W'(LAST_FIELD_POS))
                begin
                    state_next = DEC_DRAIN;
                end
            end
            DEC_DRAIN:
            begin
                proc_valid_next = 1'b0;
                emit_req.start  = (match_next >= 2'd2) && (n_next != '0);
                emit_req.count  = n_next;
                state_next      = DEC_IDLE;
            end
            default:
            begin
                state_next = DEC_IDLE;
            end
        endcase
    end

    assign clamp_info = clamp_reg;
    assign busy       = (state_reg != DEC_IDLE);

endmodule

FILE: rtl/core/sfrd_emitter.sv
// Result store and output stage: clamps positions and lengths, one result per transfer.
module sfrd_emitter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sfrd_pkg::res_wr_t             res_wr,
    input  sfrd_pkg::emit_req_t           emit_req,
    input  sfrd_pkg::clamp_info_t         clamp_info,
    output logic [sfrd_pkg::FID_W-1:0]    field_id,
    output logic [sfrd_pkg::VAL_W-1:0]    field_value,
    output logic                          bad_digit,
    output logic                          last_field,
    output logic                          field_valid,
    input  logic                          field_stall,
    output logic                          busy
);
    import sfrd_pkg::*;

    logic [VAL_W:0]     res_mem [NUM_FIELDS];
    logic [VAL_W:0]     rd_data_reg;
    logic               rd_en;

    emt_state_t         state_reg, state_next;
    logic [FID_W-1:0]   idx_reg, idx_next;
    logic [FID_W-1:0]   total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    logic [FID_W-1:0]   id_reg;
    logic [VAL_W-1:0]   val_reg;
    logic               bad_reg;
    logic               last_reg;

    logic               load;
    logic               is_last;
    logic               use_clamp;
    logic [CL_W-1:0]    slot;
    logic [VAL_W-1:0]   lim;
    logic [VAL_W-1:0]   rd_val;
    logic [VAL_W-1:0]   out_val;

    always_ff @(posedge clk)
    begin
        if (res_wr.en)
        begin
            res_mem[res_wr.addr] <= {res_wr.bad, res_wr.val};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= res_mem[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EMT_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        total_reg <= total_next;
        if (load)
        begin
            id_reg   <= idx_reg;
            val_reg  <= out_val;
            bad_reg  <= rd_data_reg[VAL_W];
            last_reg <= is_last;
        end
    end

    assign rd_val  = rd_data_reg[VAL_W-1:0];
    assign is_last = (idx_reg == total_reg - 5'd1);

    // clamp only when the whole max group made it into the frame
    always_comb
    begin
        use_clamp = 1'b0;
        slot      = CL_X;
        if (total_reg > FLD_Z_MAX)
        begin
            if (idx_reg == FLD_X_POS)
            begin
                use_clamp = 1'b1;
                slot      = CL_X;
            end
            if (idx_reg == FLD_Y_POS)
            begin
                use_clamp = 1'b1;
                slot      = CL_Y;
            end
            if (idx_reg == FLD_Z_POS)
            begin
                use_clamp = 1'b1;
                slot      = CL_Z;
            end
        end
        if (total_reg > FLD_L2_MAX)
        begin
            if (idx_reg == FLD_L1_USED)
            begin
                use_clamp = 1'b1;
                slot      = CL_L1;
            end
            if (idx_reg == FLD_L2_USED)
            begin
                use_clamp = 1'b1;
                slot      = CL_L2;
            end
        end
        lim     = clamp_info.val[slot];
        out_val = (use_clamp && !clamp_info.bad[slot] && rd_val > lim) ? lim : rd_val;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg & field_stall;
        rd_en          = 1'b0;
        load           = 1'b0;

        unique case (state_reg)
            EMT_IDLE:
            begin
                if (emit_req.start)
                begin
                    total_next = emit_req.count;
                    idx_next   = '0;
                    state_next = EMT_READ;
                end
            end
            EMT_READ:
            begin
                rd_en      = 1'b1;
                state_next = EMT_SHOW;
            end
            EMT_SHOW:
            begin
                if (!out_valid_reg || !field_stall)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    if (is_last)
                    begin
                        state_next = EMT_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 5'd1;
                        state_next = EMT_READ;
                    end
                end
            end
            default:
            begin
                state_next = EMT_IDLE;
            end
        endcase
    end

    assign field_id    = id_reg;
    assign field_value = val_reg;
    assign bad_digit   = bad_reg;
    assign last_field  = last_reg;
    assign field_valid = out_valid_reg;
    assign busy        = (state_reg != EMT_IDLE) || out_valid_reg;

endmodule

FILE: rtl/core/status_frame_receiver_decoder_top.sv
// Top level: register port, byte intake into the frame store, scanner and output stage.
// A byte that is not a terminator is taken without a stall; rx_stall stays low between frames.
// After a terminator the scanner reads store positions 1 to 75, one per cycle.
// With an address match each result then passes a result store read and an output load,
// and waits while field_stall is high; rx_stall is high during scan and emission.
// Reset clears write position, control state and output valid, and loads the register
// defaults; frame store contents stay undefined, with no clearing pass.
module status_frame_receiver_decoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfrd_pkg::PADDR_W-1:0]    paddr,
    input  logic [sfrd_pkg::DATA_W-1:0]     pwdata,
    output logic [sfrd_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic [sfrd_pkg::BYTE_W-1:0]     rx_byte,
    input  logic                            rx_valid,
    output logic                            rx_stall,
    output logic [sfrd_pkg::FID_W-1:0]      field_id,
    output logic [sfrd_pkg::VAL_W-1:0]      field_value,
    output logic                            bad_digit,
    output logic                            last_field,
    output logic                            field_valid,
    input  logic                            field_stall
);
    import sfrd_pkg::*;

    logic [VAL_W-1:0]   ext_cap_reg;
    logic [VAL_W-1:0]   bed_cap_reg;
    logic [VAL_W-1:0]   pct_cap_reg;
    logic [BYTE_W-1:0]  addr_char_reg;
    cfg_reg_t           reg_sel;
    logic               cfg_wr;

    logic [POS_W-1:0]   wp_reg, wp_next;
    logic               rx_xfer;
    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [BYTE_W-1:0]  mem_wr_data;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [BYTE_W-1:0]  mem_rd_data;
    logic               dec_start;
    logic [POS_W-1:0]   dec_count;
    logic               dec_busy;
    logic               emt_busy;

    res_wr_t            res_wr;
    clamp_info_t        clamp_info;
    emit_req_t          emit_req;

    assign pready  = 1'b1;
    assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_cap_reg   <= EXT_CAP_RST;
            bed_cap_reg   <= BED_CAP_RST;
            pct_cap_reg   <= PCT_CAP_RST;
            addr_char_reg <= ADDR_CHAR_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_EXT_CAP:   ext_cap_reg   <= pwdata[VAL_W-1:0];
                REG_BED_CAP:   bed_cap_reg   <= pwdata[VAL_W-1:0];
                REG_PCT_CAP:   pct_cap_reg   <= pwdata[VAL_W-1:0];
                REG_ADDR_CHAR: addr_char_reg <= pwdata[BYTE_W-1:0];
                default:       ext_cap_reg   <= ext_cap_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_EXT_CAP:   prdata = DATA_W'(ext_cap_reg);
            REG_BED_CAP:   prdata = DATA_W'(bed_cap_reg);
            REG_PCT_CAP:   prdata = DATA_W'(pct_cap_reg);
            REG_ADDR_CHAR: prdata = DATA_W'(addr_char_reg);
            default:       prdata = '0;
        endcase
    end

    // byte intake
    assign rx_stall = dec_busy | emt_busy;
    assign rx_xfer  = rx_valid & ~rx_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
        end
    end

    always_comb
    begin
        wp_next     = wp_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = wp_reg[ADDR_W-1:0];
        mem_wr_data = rx_byte;
        dec_start   = 1'b0;
        dec_count   = wp_reg + POS_W'(1);
        if (rx_xfer)
        begin
            if (rx_byte == CH_START)
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = '0;
                wp_next     = POS_W'(1);
            end
            else if (wp_reg < POS_W'(FRAME_BYTES))
            begin
                mem_wr_en = 1'b1;
                if (rx_byte == CH_TERM)
                begin
                    wp_next   = '0;
                    dec_start = 1'b1;
                end
                else
                begin
                    wp_next = wp_reg + POS_W'(1);
                end
            end
        end
    end

    sfrd_frame_mem u_frame_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    sfrd_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (dec_start),
        .count      (dec_count),
        .ext_cap    (ext_cap_reg),
        .bed_cap    (bed_cap_reg),
        .pct_cap    (pct_cap_reg),
        .addr_char  (addr_char_reg),
        .rd_en      (mem_rd_en),
        .rd_addr    (mem_rd_addr),
        .rd_data    (mem_rd_data),
        .res_wr     (res_wr),
        .clamp_info (clamp_info),
        .emit_req   (emit_req),
        .busy       (dec_busy)
    );

    sfrd_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .res_wr      (res_wr),
        .emit_req    (emit_req),
        .clamp_info  (clamp_info),
        .field_id    (field_id),
        .field_value (field_value),
        .bad_digit   (bad_digit),
        .last_field  (last_field),
        .field_valid (field_valid),
        .field_stall (field_stall),
        .busy        (emt_busy)
    );

endmodule
